[rtl/core/rtfs_pkg.sv]
// Shared types and constants for the region table with free-space search.
// Holds the table geometry, the entry layout, status codes and the
// request/response structures of the remainder unit. No dependencies.
package rtfs_pkg;

  // Table geometry.
  localparam int TableDepth = 64;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int CandW      = CntW + 1;

  // Fixed constants of the address map.
  localparam logic [31:0] BaseMask     = 32'hFFFF_F000;
  localparam logic [31:0] ReservedSpan = 32'h0100_0000;
  localparam logic [31:0] AllOnes      = 32'hFFFF_FFFF;

  // Remainder unit: a 33-bit dividend is taken one bit a cycle.
  localparam int DivSteps = 33;
  localparam int DivCntW  = $clog2(DivSteps + 1);

  // One table entry as held in the memory.
  typedef struct packed {
    logic [31:0] virt;
    logic [31:0] phys;
    logic [31:0] size;
    logic [31:0] mode;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // Actions carried by an input transaction.
  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  // Status codes carried by a result transaction.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_NOFREE = 2'd2,
    ST_NOIDX  = 2'd3
  } status_t;

  // Request to the remainder unit.
  typedef struct packed {
    logic        start;
    logic [32:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  // Response from the remainder unit.
  typedef struct packed {
    logic        done;
    logic [31:0] rem;
  } div_resp_t;

endpackage

[rtl/core/region_table_free_search.sv]
// Region table with free-space search. One transaction carries one action
// and gives one result transaction. A remove does one memory read per
// valid entry and one compaction write per entry that it keeps. A find
// tries up to N+2 candidate addresses for N valid entries; each is rounded
// up to the alignment in the bit-serial remainder unit and then checked
// against the reserved span and by a walk over the table memory. The table
// memory has a single read port, which sets the per-entry cost of every
// walk. A new transaction is taken while a finished result still waits.
module region_table_free_search (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [31:0] virt_addr,
  input  logic [31:0] phys_addr,
  input  logic [31:0] region_size,
  input  logic [31:0] mode_bits,
  input  logic [31:0] range_start,
  input  logic [31:0] range_end,
  input  logic [31:0] request_align,
  input  logic [5:0]  entry_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [31:0] found_addr,
  output logic [31:0] read_virt,
  output logic [31:0] read_phys,
  output logic [31:0] read_size,
  output logic [31:0] read_mode,
  output logic [6:0]  entry_count,
  output logic [6:0]  removed_count
);
  import rtfs_pkg::*;

  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  entry_t            ram_wdata;
  logic [IdxW-1:0]   ram_raddr;
  logic [EntryW-1:0] ram_rdata;
  div_req_t          div_req;
  div_resp_t         div_resp;

  // Sequencer.
  rtfs_ctrl u_ctrl (
    .clk, .rst, .cfg_we, .cfg_data, .in_valid, .in_stall, .action,
    .virt_addr, .phys_addr, .region_size, .mode_bits, .range_start,
    .range_end, .request_align, .entry_index, .out_valid, .out_stall,
    .status, .found_addr, .read_virt, .read_phys, .read_size, .read_mode,
    .entry_count, .removed_count,
    .ram_we, .ram_waddr, .ram_wdata, .ram_raddr,
    .ram_rdata (entry_t'(ram_rdata)),
    .div_req, .div_resp
  );

  // Table memory, one entry per word.
  rtfs_ram #(.Depth(TableDepth), .Width(EntryW)) u_ram (
    .clk,
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Alignment remainder unit.
  rtfs_divider u_div (
    .clk, .rst,
    .req  (div_req),
    .resp (div_resp)
  );

endmodule

[rtl/core/rtfs_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; geometry comes from its parameters.
module rtfs_ram #(
  parameter int Depth = 64,
  parameter int Width = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, with registered read data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/rtfs_divider.sv]
// Bit-serial remainder unit: gives dividend modulo divisor for a 33-bit
// dividend and a non-zero 32-bit divisor. Depends on rtfs_pkg.
module rtfs_divider (
  input  logic                 clk,
  input  logic                 rst,
  input  rtfs_pkg::div_req_t   req,
  output rtfs_pkg::div_resp_t  resp
);
  import rtfs_pkg::*;

  logic [31:0]         rem;
  logic [32:0]         shreg;
  logic [31:0]         dvs;
  logic [DivCntW-1:0]  cnt;
  logic                busy;
  logic                done;
  logic [32:0]         trial;

  // Bring in the next dividend bit below the shifted partial remainder.
  assign trial = {rem, shreg[32]};

  // Restoring step, one dividend bit a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        rem   <= '0;
        shreg <= req.dividend;
        dvs   <= req.divisor;
        cnt   <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, dvs}) begin
          rem <= 32'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[31:0];
        end
        shreg <= {shreg[31:0], 1'b0};
        cnt   <= cnt + DivCntW'(1);
        if (cnt == DivCntW'(DivSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign resp.done = done;
  assign resp.rem  = rem;

endmodule

[rtl/core/rtfs_ctrl.sv]
// Sequencer of the region table: takes transactions, walks the table memory
// for remove and find, writes it on add, reads it on read; holds the result
// register. Uses rtfs_pkg; drives rtfs_ram and rtfs_divider from the top level.
module rtfs_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [31:0]              cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               action,
  input  logic [31:0]              virt_addr,
  input  logic [31:0]              phys_addr,
  input  logic [31:0]              region_size,
  input  logic [31:0]              mode_bits,
  input  logic [31:0]              range_start,
  input  logic [31:0]              range_end,
  input  logic [31:0]              request_align,
  input  logic [5:0]               entry_index,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic [31:0]              found_addr,
  output logic [31:0]              read_virt,
  output logic [31:0]              read_phys,
  output logic [31:0]              read_size,
  output logic [31:0]              read_mode,
  output logic [6:0]               entry_count,
  output logic [6:0]               removed_count,
  output logic                     ram_we,
  output logic [rtfs_pkg::IdxW-1:0] ram_waddr,
  output rtfs_pkg::entry_t         ram_wdata,
  output logic [rtfs_pkg::IdxW-1:0] ram_raddr,
  input  rtfs_pkg::entry_t         ram_rdata,
  output rtfs_pkg::div_req_t       div_req,
  input  rtfs_pkg::div_resp_t      div_resp
);
  import rtfs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RM_RD,
    S_RM_CHK,
    S_F_CAND,
    S_F_CRD,
    S_F_CDAT,
    S_F_DIV,
    S_F_SRD,
    S_F_SCHK,
    S_RD_DAT,
    S_DONE
  } state_t;

  state_t          state;
  logic [31:0]     pt_base;
  logic [CntW-1:0] count;
  logic [CntW-1:0] ptr;
  logic [CntW-1:0] wptr;
  logic [CandW-1:0] cand;
  logic [CntW-1:0] removed;
  logic            got;
  logic [31:0]     best;
  logic [31:0]     cur_a;
  logic [32:0]     cur_e;
  logic [31:0]     req_size;
  logic [31:0]     step;
  logic [31:0]     rng_lo;
  logic [31:0]     rng_hi;
  status_t         res_status;
  logic [31:0]     res_found;
  entry_t          res_entry;

  logic [32:0]     base_w;
  logic [32:0]     span_end;
  logic [31:0]     limit;
  logic [33:0]     aligned;
  logic            hit_reserved;
  logic            hit_entry;
  logic            accept;

  // Two half-open intervals overlap when both are non-empty and each starts
  // below the end of the other; ends are taken in 34 bits.
  function automatic logic overlap(input logic [31:0] a, input logic [31:0] as,
                                   input logic [32:0] b, input logic [31:0] bs);
    logic [33:0] a_end;
    logic [33:0] b_end;
    a_end = {2'b00, a} + {2'b00, as};
    b_end = {1'b0, b} + {2'b00, bs};
    overlap = (as != '0) && (bs != '0) && ({1'b0, b} < a_end) &&
              (b_end > {2'b00, a});
  endfunction

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);

  // Reserved span and candidate limit.
  assign base_w   = {1'b0, pt_base & BaseMask};
  assign span_end = base_w + {1'b0, ReservedSpan};
  assign limit    = AllOnes - step;

  // Candidate rounded up to the alignment from the remainder.
  assign aligned = (div_resp.rem == '0) ? {1'b0, cur_e} :
                   34'({1'b0, cur_e} + {2'b00, step} - {2'b00, div_resp.rem});

  assign hit_reserved = overlap(cur_a, req_size, base_w, ReservedSpan);
  assign hit_entry    = overlap(cur_a, req_size, {1'b0, ram_rdata.phys}, ram_rdata.size);

  // Memory read address: the requested entry at accept, the walk pointer after.
  assign ram_raddr = (state == S_IDLE) ? entry_index[IdxW-1:0] : ptr[IdxW-1:0];

  // Memory write: append on add, compaction on remove.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[IdxW-1:0];
    ram_wdata = '{virt: virt_addr, phys: phys_addr, size: region_size, mode: mode_bits};
    if (accept && action == ACT_ADD && count < CntW'(TableDepth)) begin
      ram_we = 1'b1;
    end else if (state == S_RM_CHK) begin
      ram_waddr = wptr[IdxW-1:0];
      ram_wdata = ram_rdata;
      ram_we    = !(ram_rdata.virt >= rng_lo && ram_rdata.virt < rng_hi);
    end
  end

  // Remainder unit request, raised for one cycle per candidate.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = step;
    if (state == S_F_CAND && cand < ({1'b0, count} + CandW'(2))) begin
      div_req.start = (cand < CandW'(2));
      div_req.dividend = (cand == '0) ? 33'd0 : span_end;
    end else if (state == S_F_CDAT) begin
      div_req.start    = 1'b1;
      div_req.dividend = {1'b0, ram_rdata.phys} + {1'b0, ram_rdata.size};
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pt_base <= '0;
    end else if (cfg_we) begin
      pt_base <= cfg_data;
    end
  end

  // Main sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // A taken result leaves the register unless a new one is loaded now.
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            req_size   <= region_size;
            step       <= (request_align == '0) ? 32'd1 : request_align;
            rng_lo     <= range_start;
            rng_hi     <= range_end;
            res_status <= ST_OK;
            res_found  <= '0;
            res_entry  <= '0;
            removed    <= '0;
            ptr        <= '0;
            wptr       <= '0;
            cand       <= '0;
            got        <= 1'b0;
            case (action)
              ACT_ADD: begin
                if (count < CntW'(TableDepth)) begin
                  count <= count + CntW'(1);
                end else begin
                  res_status <= ST_FULL;
                end
                state <= S_DONE;
              end
              ACT_REMOVE: begin
                state <= (count == '0) ? S_DONE : S_RM_RD;
              end
              ACT_FIND: begin
                state <= S_F_CAND;
              end
              default: begin
                if ({1'b0, entry_index} < count) begin
                  state <= S_RD_DAT;
                end else begin
                  res_status <= ST_NOIDX;
                  state      <= S_DONE;
                end
              end
            endcase
          end
        end
        S_RD_DAT: begin
          res_entry <= ram_rdata;
          state     <= S_DONE;
        end
        S_RM_RD: begin
          state <= S_RM_CHK;
        end
        S_RM_CHK: begin
          if (ram_we) begin
            wptr <= wptr + CntW'(1);
          end else begin
            removed <= removed + CntW'(1);
          end
          if (ptr + CntW'(1) == count) begin
            count <= ram_we ? wptr + CntW'(1) : wptr;
            state <= S_DONE;
          end else begin
            ptr   <= ptr + CntW'(1);
            state <= S_RM_RD;
          end
        end
        S_F_CAND: begin
          if (cand == {1'b0, count} + CandW'(2)) begin
            res_status <= got ? ST_OK : ST_NOFREE;
            res_found  <= got ? best : 32'd0;
            state      <= S_DONE;
          end else if (cand < CandW'(2)) begin
            cur_e <= div_req.dividend;
            state <= S_F_DIV;
          end else begin
            ptr   <= CntW'(cand - CandW'(2));
            state <= S_F_CRD;
          end
        end
        S_F_CRD: begin
          state <= S_F_CDAT;
        end
        S_F_CDAT: begin
          cur_e <= div_req.dividend;
          state <= S_F_DIV;
        end
        S_F_DIV: begin
          if (div_resp.done) begin
            if (aligned >= {2'b00, limit} || (got && aligned >= {2'b00, best})) begin
              cand  <= cand + CandW'(1);
              state <= S_F_CAND;
            end else begin
              cur_a <= aligned[31:0];
              ptr   <= '0;
              state <= S_F_SRD;
            end
          end
        end
        S_F_SRD: begin
          // The reserved span is tested here, while each entry is read.
          if (hit_reserved) begin
            cand  <= cand + CandW'(1);
            state <= S_F_CAND;
          end else if (count == '0) begin
            got   <= 1'b1;
            best  <= cur_a;
            cand  <= cand + CandW'(1);
            state <= S_F_CAND;
          end else begin
            state <= S_F_SCHK;
          end
        end
        S_F_SCHK: begin
          if (hit_entry) begin
            cand  <= cand + CandW'(1);
            state <= S_F_CAND;
          end else if (ptr + CntW'(1) == count) begin
            got   <= 1'b1;
            best  <= cur_a;
            cand  <= cand + CandW'(1);
            state <= S_F_CAND;
          end else begin
            ptr   <= ptr + CntW'(1);
            state <= S_F_SRD;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            found_addr    <= res_found;
            read_virt     <= res_entry.virt;
            read_phys     <= res_entry.phys;
            read_size     <= res_entry.size;
            read_mode     <= res_entry.mode;
            entry_count   <= count;
            removed_count <= removed;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/rtfs_checker.sv]
// Port-level checks for the region table, bound to the top level.
// Depends on rtfs_pkg for the status codes.
module rtfs_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  status,
  input logic [31:0] found_addr,
  input logic [6:0]  entry_count
);
  import rtfs_pkg::*;

  // The result register is empty after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // A stalled result holds its status.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("stalled result changed");

  // The count never exceeds the table depth.
  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= 7'(TableDepth))
    else $error("entry count beyond depth");

  // A refused add reports a full table.
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> entry_count == 7'(TableDepth))
    else $error("full status with room left");

  // A non-zero address is only reported by a successful find.
  a_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && found_addr != '0 |-> status == ST_OK)
    else $error("address reported with failure status");

endmodule

bind region_table_free_search rtfs_checker u_rtfs_checker (.*);

[dv/tb_top.sv]
// Self-checking testbench for region_table_free_search: directed and random
// transactions checked against a behavioural table model held here.
// Depends on rtfs_pkg and the region_table_free_search RTL.
module tb_top;
  import rtfs_pkg::*;

  localparam int IdleLimit = 200000;
  localparam int DrainWait = 50;

  // Input transaction and expected result layouts.
  typedef struct {
    action_t     act;
    logic [31:0] va, pa, sz, md, rs, re, al;
    logic [5:0]  idx;
  } req_t;

  typedef struct {
    status_t     st;
    logic [31:0] found, rv, rp, rsz, rm;
    logic [6:0]  cnt, removed;
  } result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = '0;
  logic [31:0] virt_addr = '0, phys_addr = '0, region_size = '0, mode_bits = '0;
  logic [31:0] range_start = '0, range_end = '0, request_align = 32'd1;
  logic [5:0]  entry_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] found_addr, read_virt, read_phys, read_size, read_mode;
  logic [6:0]  entry_count, removed_count;

  // Model state of the table and the reserved-span register.
  logic [31:0] tab_virt[TableDepth];
  logic [31:0] tab_phys[TableDepth];
  logic [31:0] tab_size[TableDepth];
  logic [31:0] tab_mode[TableDepth];
  int unsigned tab_count = 0;
  logic [31:0] pt_base = '0;

  result_t pending_results[$];
  int      mismatches = 0;
  int      stall_left = 0;
  int      idle_cycles = 0;
  bit      no_idle = 0;

  region_table_free_search i_dut (
    .clk, .rst, .cfg_we, .cfg_data, .in_valid, .in_stall, .action, .virt_addr,
    .phys_addr, .region_size, .mode_bits, .range_start, .range_end,
    .request_align, .entry_index, .out_valid, .out_stall, .status, .found_addr,
    .read_virt, .read_phys, .read_size, .read_mode, .entry_count, .removed_count
  );

  always #5 clk = ~clk;

  // Half-open interval overlap with wide sums; empty intervals never overlap.
  function automatic bit spans_meet(longint unsigned a, longint unsigned as,
                                    longint unsigned b, longint unsigned bs);
    if (as == 0 || bs == 0) return 1'b0;
    return (b < a + as) && (b + bs > a);
  endfunction

  function automatic bit region_is_free(longint unsigned a, longint unsigned sz);
    if (spans_meet(a, sz, pt_base & BaseMask, ReservedSpan)) return 1'b0;
    for (int j = 0; j < tab_count; j++)
      if (spans_meet(a, sz, tab_phys[j], tab_size[j])) return 1'b0;
    return 1'b1;
  endfunction

  // Applies one accepted transaction to the model and returns its result.
  function automatic result_t apply_table_action(req_t r);
    result_t         res;
    int unsigned     w;
    longint unsigned step, limit, best, e, a;
    bit              got;
    res = '{st: ST_OK, default: '0};
    case (r.act)
      ACT_ADD: begin
        if (tab_count >= TableDepth) begin
          res.st = ST_FULL;
        end else begin
          tab_virt[tab_count] = r.va;
          tab_phys[tab_count] = r.pa;
          tab_size[tab_count] = r.sz;
          tab_mode[tab_count] = r.md;
          tab_count++;
        end
      end
      ACT_REMOVE: begin
        w = 0;
        for (int i = 0; i < tab_count; i++) begin
          if (tab_virt[i] >= r.rs && tab_virt[i] < r.re) begin
            res.removed++;
          end else begin
            tab_virt[w] = tab_virt[i];
            tab_phys[w] = tab_phys[i];
            tab_size[w] = tab_size[i];
            tab_mode[w] = tab_mode[i];
            w++;
          end
        end
        tab_count = w;
      end
      ACT_FIND: begin
        step  = (r.al == 0) ? 1 : r.al;
        limit = 32'(AllOnes - 32'(step));
        got   = 1'b0;
        best  = 0;
        // Candidates: zero, the end of the reserved span, each entry end.
        for (int c = -2; c < int'(tab_count); c++) begin
          if (c == -2) e = 0;
          else if (c == -1) e = longint'(pt_base & BaseMask) + ReservedSpan;
          else e = longint'(tab_phys[c]) + tab_size[c];
          a = ((e + step - 1) / step) * step;
          if (a < limit && !(got && a >= best) && region_is_free(a, r.sz)) begin
            got  = 1'b1;
            best = a;
          end
        end
        if (got) res.found = best[31:0];
        else res.st = ST_NOFREE;
      end
      default: begin
        if (r.idx < tab_count) begin
          res.rv  = tab_virt[r.idx];
          res.rp  = tab_phys[r.idx];
          res.rsz = tab_size[r.idx];
          res.rm  = tab_mode[r.idx];
        end else begin
          res.st = ST_NOIDX;
        end
      end
    endcase
    res.cnt = tab_count[6:0];
    return res;
  endfunction

  // Sends one input transaction after a random gap, or none in no-idle phases, and records its result.
  task automatic send_action(req_t r);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    action        <= r.act;
    virt_addr     <= r.va;
    phys_addr     <= r.pa;
    region_size   <= r.sz;
    mode_bits     <= r.md;
    range_start   <= r.rs;
    range_end     <= r.re;
    request_align <= r.al;
    entry_index   <= r.idx;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_table_action(r));
  endtask

  // Random field contents, so that every input bit toggles.
  function automatic req_t random_req(action_t act);
    req_t r;
    r.act = act;
    r.va  = $urandom;
    r.pa  = $urandom;
    r.sz  = $urandom;
    r.md  = $urandom;
    r.rs  = $urandom;
    r.re  = $urandom;
    r.al  = $urandom_range(1, 32'h8000_0000);
    r.idx = 6'($urandom_range(0, 63));
    return r;
  endfunction

  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // Register write, done only while nothing is in flight.
  task automatic write_base(logic [31:0] v);
    wait_idle();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(negedge clk) cfg_we <= 1'b0;
    pt_base = v;
  endtask

  task automatic do_add(logic [31:0] va, pa, sz, md);
    req_t r;
    r = random_req(ACT_ADD);
    r.va = va; r.pa = pa; r.sz = sz; r.md = md;
    send_action(r);
  endtask

  task automatic do_remove(logic [31:0] rs, re);
    req_t r;
    r = random_req(ACT_REMOVE);
    r.rs = rs; r.re = re;
    send_action(r);
  endtask

  task automatic do_find(logic [31:0] sz, al);
    req_t r;
    r = random_req(ACT_FIND);
    r.sz = sz; r.al = al;
    send_action(r);
  endtask

  task automatic do_read(logic [5:0] idx);
    req_t r;
    r = random_req(ACT_READ);
    r.idx = idx;
    send_action(r);
  endtask

  // Empty table: reads out of range and finds against the reserved span.
  task automatic test_empty_table();
    do_read(6'd0);
    do_read(6'd63);
    do_find(32'd0, 32'd1);
    do_find(32'hFFFF_FFFF, 32'd1);
    do_find(32'h1000, 32'h8000_0000);
  endtask

  // Adds with extreme fields, read back, a find, then removals of several kinds.
  task automatic test_add_remove();
    do_add(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    do_add(32'h0, 32'h0, 32'h0, 32'h0);
    do_add(32'h1000_0000, 32'h0200_0000, 32'h10_0000, 32'h5A5A_A5A5);
    do_read(6'd0);
    do_read(6'd1);
    do_read(6'd2);
    do_read(6'd3);
    do_find(32'h1000, 32'h1000);
    do_remove(32'h2000_0000, 32'h1000_0000);
    do_remove(32'h1000_0000, 32'h1000_0001);
    do_remove(32'h0, 32'hFFFF_FFFF);
    do_remove(32'h0, 32'hFFFF_FFFF);
  endtask

  // A search that cannot succeed, then searches at a large and an odd alignment.
  task automatic test_find_limits();
    do_add(32'h0, 32'h2000_0000, 32'hE000_0000, 32'h1);
    do_find(32'hFFFF_FFFF, 32'd1);
    do_find(32'h10, 32'h8000_0000);
    do_find(32'h10, 32'h0000_0003);
    do_remove(32'h0, 32'hFFFF_FFFF);
  endtask

  // Fills the table, checks refusal, then reads, searches and empties the full table.
  task automatic test_full_table();
    for (int i = 0; i < TableDepth; i++)
      do_add(i << 20, (i + 32) << 20, 32'h8_0000, $urandom);
    do_add(32'h1, 32'h1, 32'h1, 32'h1);
    do_read(6'd63);
    do_find(32'h10_0000, 32'h10_0000);
    do_remove(32'h0, 32'hFFFF_FFFF);
  endtask

  // Mostly structured traffic with a small table; some fully random noise.
  task automatic test_random_mix(int n);
    req_t r;
    int   pick;
    for (int k = 0; k < n; k++) begin
      if (k % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (tab_count > 12 && pick < 50) begin
        r = random_req(ACT_REMOVE);
        if ($urandom_range(0, 1)) begin
          r.rs = 32'h0;
          r.re = 32'hFFFF_FFFF;
        end
      end else if (pick < 40) begin
        r = random_req(ACT_ADD);
        r.va = {4'($urandom_range(0, 15)), 28'($urandom)};
        if ($urandom_range(0, 2) != 0) r.pa = $urandom_range(0, 32'h0800_0000) & BaseMask;
        case ($urandom_range(0, 3))
          0: r.sz = 32'h0;
          1: r.sz = $urandom_range(1, 32'h20_0000);
          2: r.sz = 32'h1000 << $urandom_range(0, 12);
          default: ;
        endcase
      end else if (pick < 55) begin
        r = random_req(ACT_REMOVE);
        r.rs = {4'($urandom_range(0, 15)), 28'($urandom)};
        if ($urandom_range(0, 3) != 0) r.re = r.rs + {4'($urandom_range(0, 8)), 28'h0};
      end else if (pick < 80) begin
        r = random_req(ACT_FIND);
        if ($urandom_range(0, 2) != 0) r.al = 32'd1 << $urandom_range(0, 31);
        case ($urandom_range(0, 3))
          0: r.sz = 32'h0;
          1: r.sz = $urandom_range(1, 32'h100_0000);
          2: r.sz = 32'hFFFF_FFFF;
          default: ;
        endcase
      end else begin
        r = random_req(ACT_READ);
        if ($urandom_range(0, 1) && tab_count > 0) r.idx = 6'($urandom_range(0, tab_count));
      end
      send_action(r);
    end
  endtask

  // Reports the first mismatches in full; later ones are only counted.
  task automatic flag_mismatch(string field, logic [31:0] exp_v, logic [31:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch on %s: expected %h, got %h", field, exp_v, got_v);
  endtask

  // Result checker and receiver-side stalls.
  always @(posedge clk) begin
    result_t e;
    if (!rst && out_valid && !out_stall) begin
      stall_left = no_idle ? 0 : $urandom_range(0, 10);
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", '0, {30'h0, status});
      end else begin
        e = pending_results.pop_front();
        if (status !== e.st) flag_mismatch("status", {30'h0, e.st}, {30'h0, status});
        if (found_addr !== e.found) flag_mismatch("found_addr", e.found, found_addr);
        if (read_virt !== e.rv) flag_mismatch("read_virt", e.rv, read_virt);
        if (read_phys !== e.rp) flag_mismatch("read_phys", e.rp, read_phys);
        if (read_size !== e.rsz) flag_mismatch("read_size", e.rsz, read_size);
        if (read_mode !== e.rm) flag_mismatch("read_mode", e.rm, read_mode);
        if (entry_count !== e.cnt)
          flag_mismatch("entry_count", {25'h0, e.cnt}, {25'h0, entry_count});
        if (removed_count !== e.removed)
          flag_mismatch("removed_count", {25'h0, e.removed}, {25'h0, removed_count});
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  // Watchdog on cycles without any accepted transaction or taken result.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_empty_table();
    test_add_remove();
    write_base(32'h0000_3000);
    test_find_limits();
    write_base(32'hFFFF_F000);
    test_full_table();
    test_empty_table();
    test_random_mix(480);
    write_base(32'h0000_0FFF);
    test_random_mix(480);
    write_base($urandom & 32'h0FFF_FFFF);
    test_random_mix(480);
    write_base($urandom);
    test_random_mix(420);
    wait_idle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
